FILE: hdl/mcld_pkg.sv
// Shared types and constants for the multi-click and long-press detector.
package mcld_pkg;

   localparam int BUTTONS = 2;

   typedef logic [2:0]         idx_type;
   typedef logic [2:0]         act_type;
   typedef logic [3:0]         count_type;
   typedef logic [7:0]         key_type;
   typedef logic [3:0]         keys_type;
   typedef logic [19:0]        reg_type;
   typedef logic [31:0]        stamp_type;
   typedef logic [BUTTONS-1:0] btn_mask_type;
   typedef logic [0:0]         csr_index_type;

   typedef enum logic [1:0] {
      MODE_NORMAL,
      MODE_PRESSED,
      MODE_LONG,
      MODE_RELEASED
   } mode_type;

   localparam csr_index_type REG_LONG_PRESS  = 1'd0;
   localparam csr_index_type REG_RELEASE_GAP = 1'd1;

   localparam reg_type   LONG_PRESS_RESET  = 20'd5000;
   localparam reg_type   RELEASE_GAP_RESET = 20'd250;
   localparam key_type   NO_KEY            = 8'hff;
   localparam count_type COUNT_MAX         = 4'd15;
   localparam count_type CLICK_MAX         = 4'd5;
   localparam act_type   ACT_NONE          = 3'd0;
   localparam act_type   ACT_LONG          = 3'd6;

   typedef struct packed {
      logic     func;
      keys_type keys_down;
      key_type  first_key;
   } req_type;

   // Everything one tick reports: a fired flag and action per button, plus busy.
   typedef struct packed {
      btn_mask_type               fired;
      act_type [BUTTONS-1:0]      action;
      logic                       busy;
   } bundle_type;

endpackage

FILE: hdl/mcld_engine.sv
// Per-button state, timeout checks and key-scan update for one tick.
module mcld_engine (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 proc,
   input  mcld_pkg::req_type    item,
   input  mcld_pkg::reg_type    long_ticks,
   input  mcld_pkg::reg_type    gap_ticks,
   output mcld_pkg::bundle_type bundle
);

   // tick_ff holds the tick count as it stands before this tick's increment
   mcld_pkg::stamp_type tick_ff, tick_in;
   mcld_pkg::mode_type  mode_ff   [mcld_pkg::BUTTONS];
   mcld_pkg::mode_type  mode_in   [mcld_pkg::BUTTONS];
   mcld_pkg::count_type count_ff  [mcld_pkg::BUTTONS];
   mcld_pkg::count_type count_in  [mcld_pkg::BUTTONS];
   mcld_pkg::stamp_type pstamp_ff [mcld_pkg::BUTTONS];
   mcld_pkg::stamp_type pstamp_in [mcld_pkg::BUTTONS];
   mcld_pkg::stamp_type rstamp_ff [mcld_pkg::BUTTONS];
   mcld_pkg::stamp_type rstamp_in [mcld_pkg::BUTTONS];
   mcld_pkg::key_type   held_ff, held_in;
   logic                key_held_ff, key_held_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         tick_ff     <= mcld_pkg::stamp_type'(1);
         held_ff     <= mcld_pkg::NO_KEY;
         key_held_ff <= 1'b0;
         for (int b = 0; b < mcld_pkg::BUTTONS; b++) begin
            mode_ff[b]  <= mcld_pkg::MODE_NORMAL;
            count_ff[b] <= '0;
         end
      end else if (proc) begin
         tick_ff     <= tick_in;
         held_ff     <= held_in;
         key_held_ff <= key_held_in;
         for (int b = 0; b < mcld_pkg::BUTTONS; b++) begin
            mode_ff[b]  <= mode_in[b];
            count_ff[b] <= count_in[b];
         end
      end
   end

   // stamps are read only in pressed or released mode, which writes them first
   always_ff @(posedge clock) begin
      if (proc) begin
         for (int b = 0; b < mcld_pkg::BUTTONS; b++) begin
            pstamp_ff[b] <= pstamp_in[b];
            rstamp_ff[b] <= rstamp_in[b];
         end
      end
   end

   always_comb begin
      mcld_pkg::stamp_type press_age;
      mcld_pkg::stamp_type rel_age;
      mcld_pkg::key_type   code;
      logic                any_count;

      tick_in     = tick_ff + mcld_pkg::stamp_type'(1);
      held_in     = held_ff;
      key_held_in = key_held_ff;
      bundle      = '0;
      any_count   = 1'b0;

      for (int b = 0; b < mcld_pkg::BUTTONS; b++) begin
         mode_in[b]   = mode_ff[b];
         count_in[b]  = count_ff[b];
         pstamp_in[b] = pstamp_ff[b];
         rstamp_in[b] = rstamp_ff[b];
         press_age    = tick_ff - pstamp_ff[b];
         rel_age      = tick_ff - rstamp_ff[b];
         code         = mcld_pkg::key_type'(b + 1);

         // timeouts first
         if (mode_ff[b] == mcld_pkg::MODE_PRESSED &&
             press_age > {12'd0, long_ticks}) begin
            mode_in[b]        = mcld_pkg::MODE_LONG;
            count_in[b]       = '0;
            bundle.fired[b]   = 1'b1;
            bundle.action[b]  = mcld_pkg::ACT_LONG;
         end
         if (mode_ff[b] == mcld_pkg::MODE_RELEASED &&
             rel_age > {12'd0, gap_ticks}) begin
            mode_in[b]  = mcld_pkg::MODE_NORMAL;
            count_in[b] = '0;
            if (count_ff[b] != '0 && count_ff[b] <= mcld_pkg::CLICK_MAX) begin
               bundle.fired[b]  = 1'b1;
               bundle.action[b] = count_ff[b][2:0];
            end
         end

         // then the key-scan change
         if (item.func) begin
            if (item.keys_down != '0 && item.first_key == code) begin
               pstamp_in[b] = tick_ff;
               mode_in[b]   = mcld_pkg::MODE_PRESSED;
               if (count_in[b] != mcld_pkg::COUNT_MAX) begin
                  count_in[b] = count_in[b] + mcld_pkg::count_type'(1);
               end
            end else if (item.keys_down == '0 && held_ff == code) begin
               rstamp_in[b] = tick_ff;
               mode_in[b]   = mcld_pkg::MODE_RELEASED;
            end
         end

         if (count_in[b] != '0) begin
            any_count = 1'b1;
         end
      end

      if (item.func) begin
         if (item.keys_down != '0) begin
            key_held_in = 1'b1;
            if (item.keys_down == mcld_pkg::keys_type'(1)) begin
               held_in = item.first_key;
            end
         end else begin
            held_in     = mcld_pkg::NO_KEY;
            key_held_in = 1'b0;
         end
      end

      bundle.busy = key_held_in | any_count;
   end

endmodule

FILE: hdl/mcld_out.sv
// Two-entry tick queue and serializer that sends one result per cycle while rsp_ready is high.
module mcld_out (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  mcld_pkg::bundle_type bundle,
   output logic                 full,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic                 rsp_fired,
   output mcld_pkg::idx_type    rsp_button_index,
   output mcld_pkg::act_type    rsp_action,
   output logic                 rsp_busy_res,
   output logic                 rsp_last
);

   mcld_pkg::bundle_type   queue_ff [2];
   logic                   wr_ptr_ff, rd_ptr_ff;
   logic [1:0]             count_ff;
   mcld_pkg::btn_mask_type done_ff, done_in;
   mcld_pkg::bundle_type   head;
   mcld_pkg::btn_mask_type remaining;
   mcld_pkg::idx_type      cur_idx;
   mcld_pkg::act_type      cur_act;
   logic                   xfer, pop;

   assign head      = queue_ff[rd_ptr_ff];
   assign remaining = head.fired & ~done_ff;
   assign full      = (count_ff == 2'd2);
   assign rsp_valid = (count_ff != 2'd0);
   assign xfer      = rsp_valid & rsp_ready;
   assign pop       = xfer & rsp_last;

   // lowest button still owed a result
   always_comb begin
      cur_idx = '0;
      cur_act = mcld_pkg::ACT_NONE;
      for (int i = mcld_pkg::BUTTONS - 1; i >= 0; i--) begin
         if (remaining[i]) begin
            cur_idx = mcld_pkg::idx_type'(i);
            cur_act = head.action[i];
         end
      end
   end

   assign rsp_fired        = |remaining;
   assign rsp_button_index = cur_idx;
   assign rsp_action       = cur_act;
   assign rsp_busy_res     = head.busy;
   assign rsp_last = ((remaining & (remaining - mcld_pkg::btn_mask_type'(1))) == '0);

   always_comb begin
      done_in = done_ff;
      if (pop) begin
         done_in = '0;
      end else if (xfer) begin
         done_in = done_ff | (mcld_pkg::btn_mask_type'(1) << cur_idx);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
         done_ff   <= '0;
      end else begin
         done_ff <= done_in;
         if (push) begin
            wr_ptr_ff <= ~wr_ptr_ff;
         end
         if (pop) begin
            rd_ptr_ff <= ~rd_ptr_ff;
         end
         if (push && !pop) begin
            count_ff <= count_ff + 2'd1;
         end else if (pop && !push) begin
            count_ff <= count_ff - 2'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         queue_ff[wr_ptr_ff] <= bundle;
      end
   end

endmodule

FILE: hdl/multi_click_long_press_detector_core.sv
// Multi-click and long-press detector: tick in, button action results out.
//
// Each req_ transaction is one time tick, optionally carrying a key-scan
// change (req_func, req_keys_down, req_first_key). Each tick yields one or
// more rsp_ transactions: one per fired button action in button order, or a
// single quiet result with rsp_fired low; rsp_last marks the tick's final one.
// rsp_busy_res reports a held key or any pending click count after the tick.
// The csr_ channel writes long_press_ticks (index 0) and release_gap_ticks
// (index 1); csr_ready is always high, and writes are meant for idle periods.
// The tick is registered at acceptance, then evaluated and pushed into a
// two-entry tick queue once the queue has room; rsp_valid is high while
// the queue holds a tick, and the results of its head tick are sent.
// Throughput: one tick per cycle while each tick yields one result and
// rsp_ready is high; the serializer sends a tick's results one per cycle.
// When rsp_ready is low the queue absorbs two ticks plus the input register,
// then req_ready drops; rsp payload holds steady until taken.
// Reset sets the tick counter to 1, all buttons to normal with zero counts,
// clears the held key and the queue, and sets the registers to 5000 and 250.
module multi_click_long_press_detector_core (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic                           req_func,
   input  mcld_pkg::keys_type             req_keys_down,
   input  mcld_pkg::key_type              req_first_key,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic                           rsp_fired,
   output mcld_pkg::idx_type              rsp_button_index,
   output mcld_pkg::act_type              rsp_action,
   output logic                           rsp_busy_res,
   output logic                           rsp_last,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  mcld_pkg::csr_index_type        csr_index,
   input  mcld_pkg::reg_type              csr_wdata
);

   logic                 in_valid_ff;
   mcld_pkg::req_type    in_item_ff;
   mcld_pkg::reg_type    long_ticks_ff;
   mcld_pkg::reg_type    gap_ticks_ff;
   mcld_pkg::bundle_type bundle;
   logic                 full;
   logic                 proc;

   assign proc      = in_valid_ff & ~full;
   assign req_ready = ~in_valid_ff | proc;
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_item_ff <= '{func: req_func, keys_down: req_keys_down,
                         first_key: req_first_key};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         long_ticks_ff <= mcld_pkg::LONG_PRESS_RESET;
         gap_ticks_ff  <= mcld_pkg::RELEASE_GAP_RESET;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            mcld_pkg::REG_LONG_PRESS:  long_ticks_ff <= csr_wdata;
            mcld_pkg::REG_RELEASE_GAP: gap_ticks_ff  <= csr_wdata;
            default: ;
         endcase
      end
   end

   mcld_engine u_engine (
      .clock      (clock),
      .reset      (reset),
      .proc       (proc),
      .item       (in_item_ff),
      .long_ticks (long_ticks_ff),
      .gap_ticks  (gap_ticks_ff),
      .bundle     (bundle)
   );

   mcld_out u_out (
      .clock            (clock),
      .reset            (reset),
      .push             (proc),
      .bundle           (bundle),
      .full             (full),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_fired        (rsp_fired),
      .rsp_button_index (rsp_button_index),
      .rsp_action       (rsp_action),
      .rsp_busy_res     (rsp_busy_res),
      .rsp_last         (rsp_last)
   );

endmodule

FILE: hdl/mcld_checker.sv
// Port-level checks for the detector core, bound to the top level.
module mcld_checker (
   input logic              clock,
   input logic              reset,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input logic              rsp_fired,
   input mcld_pkg::idx_type rsp_button_index,
   input mcld_pkg::act_type rsp_action,
   input logic              rsp_busy_res,
   input logic              rsp_last
);

   // a fired result carries a click count or a long press
   a_fired_action: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_fired |-> rsp_action != mcld_pkg::ACT_NONE &&
                                 rsp_action <= mcld_pkg::ACT_LONG)
      else $error("fired result without a valid action");

   // a quiet result is alone in its tick and names nothing
   a_quiet: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_fired |-> rsp_last && rsp_action == mcld_pkg::ACT_NONE &&
                                  rsp_button_index == '0)
      else $error("quiet result malformed");

   // results of one tick come in rising button order
   a_order: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && !rsp_last |=>
         rsp_valid && rsp_fired && rsp_button_index > $past(rsp_button_index))
      else $error("results out of button order");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_fired) &&
         $stable(rsp_button_index) && $stable(rsp_action) &&
         $stable(rsp_busy_res) && $stable(rsp_last))
      else $error("stalled result changed");

endmodule

bind multi_click_long_press_detector_core mcld_checker u_mcld_checker (
   .clock            (clock),
   .reset            (reset),
   .rsp_valid        (rsp_valid),
   .rsp_ready        (rsp_ready),
   .rsp_fired        (rsp_fired),
   .rsp_button_index (rsp_button_index),
   .rsp_action       (rsp_action),
   .rsp_busy_res     (rsp_busy_res),
   .rsp_last         (rsp_last)
);
